@@ rtl/udc_pkg.sv @@
package udc_pkg;

	localparam int WIDTH = 8;
	localparam int SW    = $clog2(WIDTH);

	typedef enum logic [2:0] {
		METH_IDENT   = 3'd0,
		METH_SHIFT   = 3'd1,
		METH_CMP     = 3'd2,
		METH_RUP     = 3'd3,
		METH_PRE_RUP = 3'd4,
		METH_RDOWN   = 3'd5
	} method_t;

	// derived constants handed from the setup sequencer to the datapath
	typedef struct packed {
		logic             busy;
		method_t          method;
		logic [WIDTH-1:0] divisor;
		logic [WIDTH-1:0] mult;
		logic [SW-1:0]    pre;
		logic [SW-1:0]    post;
	} derived_t;

endpackage

@@ rtl/udc_derive.sv @@
module udc_derive (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       divisor_we,
	input  logic [udc_pkg::WIDTH-1:0]  divisor,
	output udc_pkg::derived_t          cfg
);
	import udc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLASS,
		ST_DIV,
		ST_CHECK,
		ST_PRE,
		ST_TRIM
	} state_t;

	state_t              state_q;
	method_t             method_q;
	logic [WIDTH-1:0]    div_q;
	logic [WIDTH-1:0]    mult_q;
	logic [WIDTH-1:0]    rem_q;
	logic [WIDTH-1:0]    quo_q;
	logic [WIDTH-1:0]    dd_q;
	logic [SW-1:0]       l_q;
	logic [SW-1:0]       cnt_q;
	logic [SW-1:0]       pre_q;
	logic signed [SW:0]  post_q;

	logic [SW-1:0]       l_div;
	logic [WIDTH-1:0]    r2;
	logic [WIDTH-1:0]    m_up;
	logic [2*WIDTH-1:0]  chk_full;
	logic [WIDTH-1:0]    chk_prod;
	logic [WIDTH:0]      half_sum;

	function automatic logic [SW-1:0] log2_floor(input logic [WIDTH-1:0] v);
		logic [SW-1:0] r;
		r = '0;
		for (int i = 0; i < WIDTH; i++) begin
			if (v[i]) begin
				r = SW'(i);
			end
		end
		return r;
	endfunction

	always_comb begin
		l_div    = log2_floor(div_q);
		r2       = rem_q << 1;
		m_up     = quo_q + WIDTH'(1);
		chk_full = (2*WIDTH)'(m_up) * (2*WIDTH)'(div_q);
		chk_prod = chk_full[WIDTH-1:0];
		half_sum = {1'b0, mult_q} + (WIDTH+1)'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			method_q <= METH_IDENT;
			div_q    <= WIDTH'(1);
			mult_q   <= '0;
			pre_q    <= '0;
			post_q   <= '0;
			rem_q    <= '0;
			quo_q    <= '0;
			dd_q     <= '0;
			l_q      <= '0;
			cnt_q    <= '0;
		end else if (divisor_we && (divisor != '0)) begin
			// a fresh write restarts the derivation
			div_q   <= divisor;
			state_q <= ST_CLASS;
		end else begin
			case (state_q)
				ST_IDLE: begin
				end
				ST_CLASS: begin
					mult_q <= '0;
					pre_q  <= '0;
					post_q <= '0;
					if (div_q == WIDTH'(1)) begin
						method_q <= METH_IDENT;
						state_q  <= ST_IDLE;
					end else if ((div_q & (div_q - WIDTH'(1))) == '0) begin
						method_q <= METH_SHIFT;
						post_q   <= $signed({1'b0, l_div});
						state_q  <= ST_IDLE;
					end else if (div_q[WIDTH-1]) begin
						method_q <= METH_CMP;
						state_q  <= ST_IDLE;
					end else begin
						l_q     <= l_div;
						rem_q   <= WIDTH'(1) << l_div;
						quo_q   <= '0;
						cnt_q   <= SW'(WIDTH - 1);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					// one quotient bit of 2^(WIDTH+l) / d per cycle
					if (r2 >= div_q) begin
						rem_q <= r2 - div_q;
						quo_q <= {quo_q[WIDTH-2:0], 1'b1};
					end else begin
						rem_q <= r2;
						quo_q <= {quo_q[WIDTH-2:0], 1'b0};
					end
					if (cnt_q == '0) begin
						state_q <= ST_CHECK;
					end else begin
						cnt_q <= cnt_q - SW'(1);
					end
				end
				ST_CHECK: begin
					if (chk_prod <= (WIDTH'(1) << l_q)) begin
						method_q <= METH_RUP;
						mult_q   <= m_up;
						post_q   <= $signed({1'b0, l_q});
						state_q  <= ST_TRIM;
					end else if (!div_q[0]) begin
						method_q <= METH_PRE_RUP;
						mult_q   <= m_up;
						pre_q    <= SW'(1);
						post_q   <= $signed({1'b0, l_q}) - (SW+1)'(1);
						dd_q     <= div_q >> 1;
						state_q  <= ST_PRE;
					end else begin
						method_q <= METH_RDOWN;
						mult_q   <= quo_q;
						post_q   <= $signed({1'b0, l_q});
						state_q  <= ST_TRIM;
					end
				end
				ST_PRE: begin
					// move factors of two from the divisor into the pre-shift
					if (!dd_q[0] && (post_q > 0)) begin
						dd_q   <= dd_q >> 1;
						pre_q  <= pre_q + SW'(1);
						post_q <= post_q - (SW+1)'(2);
						mult_q <= half_sum[WIDTH:1];
					end else begin
						state_q <= ST_TRIM;
					end
				end
				ST_TRIM: begin
					// drop trailing zeros of the multiplier against the post-shift
					if (!mult_q[0] && (post_q > 0)) begin
						mult_q <= mult_q >> 1;
						post_q <= post_q - (SW+1)'(1);
					end else begin
						if (post_q < 0) begin
							mult_q <= mult_q << 1;
							post_q <= post_q + (SW+1)'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cfg.busy    = (state_q != ST_IDLE);
		cfg.method  = method_q;
		cfg.divisor = div_q;
		cfg.mult    = mult_q;
		cfg.pre     = pre_q;
		cfg.post    = post_q[SW-1:0];
	end

endmodule

@@ rtl/udc_datapath.sv @@
module udc_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  udc_pkg::derived_t          cfg,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [udc_pkg::WIDTH-1:0]  dividend,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [udc_pkg::WIDTH-1:0]  quotient,
	output logic [2:0]                 method
);
	import udc_pkg::*;

	logic               valid_s1;
	logic [WIDTH-1:0]   dividend_s1;
	logic               valid_s2;
	logic [WIDTH-1:0]   quotient_s2;
	method_t            method_s2;

	logic               adv;
	logic               accept;
	logic [WIDTH-1:0]   n_pre;
	logic [WIDTH-1:0]   n_inc;
	logic [WIDTH-1:0]   operand;
	logic [2*WIDTH-1:0] prod;
	logic [WIDTH-1:0]   mq;
	logic [WIDTH-1:0]   q_next;

	assign adv      = !valid_s2 || !out_stall;
	assign in_stall = cfg.busy || (valid_s1 && !adv);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		n_pre = dividend_s1 >> cfg.pre;
		n_inc = (&dividend_s1) ? dividend_s1 : dividend_s1 + WIDTH'(1);
		case (cfg.method)
			METH_RUP:     operand = dividend_s1;
			METH_PRE_RUP: operand = n_pre;
			default:      operand = n_inc;
		endcase
		prod = (2*WIDTH)'(operand) * (2*WIDTH)'(cfg.mult);
		mq   = prod[2*WIDTH-1:WIDTH] >> cfg.post;
		case (cfg.method)
			METH_IDENT: q_next = dividend_s1;
			METH_SHIFT: q_next = dividend_s1 >> cfg.post;
			METH_CMP:   q_next = {{(WIDTH-1){1'b0}}, (dividend_s1 >= cfg.divisor)};
			default:    q_next = mq;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dividend_s1 <= dividend;
		end
		if (adv && valid_s1) begin
			quotient_s2 <= q_next;
			method_s2   <= cfg.method;
		end
	end

	assign out_valid = valid_s2;
	assign quotient  = quotient_s2;
	assign method    = method_s2;

endmodule

@@ rtl/unsigned_divide_by_constant.sv @@
// unsigned divide by a constant divisor held in a register
// dividend beats pass the input, then the result register; throughput: one
// beat per cycle, set by the single multiply-high stage, unless a held result or the
// setup stalls the input; a divisor write stalls it while the sequencer
// classifies it (identity, shift, compare) or divides and trims the magic
// reset (arst_n low, asynchronous): divisor 1, identity method, pipeline empty
module unsigned_divide_by_constant (
	input  logic                       clk,
	input  logic                       arst_n,
	// divisor register, zero writes are dropped
	input  logic                       divisor_we,
	input  logic [udc_pkg::WIDTH-1:0]  divisor,
	// dividend beats
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [udc_pkg::WIDTH-1:0]  dividend,
	// quotient beats
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [udc_pkg::WIDTH-1:0]  quotient,
	output logic [2:0]                 method
);
	import udc_pkg::*;

	// magic constants, shift amounts and the busy flag of the setup sequencer
	derived_t cfg;

	// setup sequencer: classifies the divisor, then runs a bit-serial divide
	// for 2^(WIDTH+l)/d and walks the pre-shift and trailing-zero reductions
	udc_derive u_derive (
		.clk        (clk),
		.arst_n     (arst_n),
		.divisor_we (divisor_we),
		.divisor    (divisor),
		.cfg        (cfg)
	);

	// input register, then pre-shift, saturating increment or neither,
	// multiply-high and post-shift into the result register; a held result
	// only blocks the input once the input register is also full
	udc_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.dividend  (dividend),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.quotient  (quotient),
		.method    (method)
	);

endmodule

@@ rtl/udc_checker.sv @@
module udc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       divisor_we,
	input logic [udc_pkg::WIDTH-1:0]  divisor,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [udc_pkg::WIDTH-1:0]  quotient,
	input logic [2:0]                 method
);
	import udc_pkg::*;

	// a held result beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	// a held result beat keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(quotient) && $stable(method))
		else $error("result payload changed while stalled");

	// a nonzero divisor write must block dividends while constants are derived
	a_setup_stall: assert property (@(posedge clk) disable iff (!arst_n)
		divisor_we && (divisor != '0) |=> in_stall)
		else $error("dividend accepted during divisor setup");

	// compare method can only yield zero or one
	a_cmp_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (method == METH_CMP) |-> (quotient <= WIDTH'(1)))
		else $error("compare method quotient out of range");

endmodule

bind unsigned_divide_by_constant udc_checker u_udc_checker (.*);
